FILE: hw/rtl/rbc_pkg.sv
// Shared types and constants for the registry block check unit.
// Holds SHA-1 constants, the queue entry type and the SHA-1 round helpers.
package rbc_pkg;

    localparam int unsigned MaxBytes    = 3584;
    localparam int unsigned CntW        = 12;
    localparam int unsigned CheckOffset = 14;
    localparam int unsigned CheckLen    = 4;
    localparam int unsigned QDepth      = 4;
    localparam int unsigned QPtrW       = 2;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // One classified beat handed from the front end to the hash engine.
    typedef struct packed {
        logic [7:0]      hash_byte;   // byte to hash, check bytes already zeroed
        logic            keep;        // byte lies within the length limit
        logic            last;        // final beat of the block
        logic [31:0]     stored;      // captured check as of this beat
        logic            over;        // overflow seen as of this beat
    } t_qent;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] k_of(input logic [6:0] t);
        if (t < 7'd20)      return 32'h5A827999;
        else if (t < 7'd40) return 32'h6ED9EBA1;
        else if (t < 7'd60) return 32'h8F1BBCDC;
        else                return 32'hCA62C1D6;
    endfunction

    function automatic logic [31:0] f_of(input logic [6:0] t, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)      return (b & c) | (~b & d);
        else if (t < 7'd40) return b ^ c ^ d;
        else if (t < 7'd60) return (b & c) | (b & d) | (c & d);
        else                return b ^ c ^ d;
    endfunction

endpackage

FILE: hw/rtl/rbc_front.sv
// Front end: accepts input beats, tracks the offset, captures the stored check.
// Depends on rbc_pkg.
module rbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output rbc_pkg::t_qent o_q_ent
);
    import rbc_pkg::*;

    logic [CntW-1:0] r_count, n_count;
    logic [31:0]     r_check, n_check;
    logic            r_over, n_over;
    logic            keep, in_chk;
    logic [CntW-1:0] rel;
    logic [4:0]      sh;

    assign o_ready   = i_q_ready;
    assign o_q_valid = i_valid;
    assign keep   = r_count < CntW'(MaxBytes);
    assign in_chk = r_count >= CntW'(CheckOffset) && r_count < CntW'(CheckOffset + CheckLen);
    assign rel    = r_count - CntW'(CheckOffset);
    assign sh     = 5'd24 - {rel[1:0], 3'b000};

    always_comb begin
        n_count = r_count;
        n_check = r_check;
        n_over  = r_over;
        if (keep) begin
            n_count = r_count + 1'b1;
            if (in_chk) n_check = r_check | ({24'd0, i_data_byte} << sh);
        end else begin
            n_over = 1'b1;
        end
        o_q_ent.hash_byte = (keep && in_chk) ? 8'd0 : i_data_byte;
        o_q_ent.keep      = keep;
        o_q_ent.last      = i_last_byte;
        o_q_ent.stored    = n_check;
        o_q_ent.over      = n_over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_check <= '0;
            r_over  <= 1'b0;
        end else if (i_valid && i_q_ready) begin
            if (i_last_byte) begin
                r_count <= '0;
                r_check <= '0;
                r_over  <= 1'b0;
            end else begin
                r_count <= n_count;
                r_check <= n_check;
                r_over  <= n_over;
            end
        end
    end
endmodule

FILE: hw/rtl/rbc_queue.sv
// Short FIFO of classified beats between front end and hash engine.
// Depends on rbc_pkg.
module rbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  rbc_pkg::t_qent i_wr_ent,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output rbc_pkg::t_qent o_rd_ent
);
    import rbc_pkg::*;

    t_qent           r_mem [QDepth];
    logic [QPtrW-1:0] r_wp, r_rp;
    logic [QPtrW:0]   r_cnt;
    logic             wr, rd;

    assign o_wr_ready = r_cnt != (QPtrW+1)'(QDepth);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_ent   = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_ent;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPtrW+1)'(wr) - (QPtrW+1)'(rd);
        end
    end
endmodule

FILE: hw/rtl/rbc_engine.sv
// Back end: packs bytes into the chunk, runs SHA-1 rounds, pads and folds the digest.
// Depends on rbc_pkg.
module rbc_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  rbc_pkg::t_qent i_q_ent,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_check_value,
    output logic [31:0]    o_stored_check,
    output logic           o_check_ok,
    output logic           o_too_long
);
    import rbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ROUND, S_PAD, S_FOLD, S_OUT
    } t_state;

    t_state          r_state;
    t_state          r_ret;       // state to go back to after a compression
    logic [31:0]     r_w [16];
    logic [31:0]     r_h [5];
    logic [31:0]     r_v [5];
    logic [6:0]      r_t;
    logic [CntW-1:0] r_len;
    logic [5:0]      r_pos;
    logic [31:0]     r_stored;
    logic            r_over;
    logic [31:0]     r_chk;
    logic            r_wrap;      // padding spilled into a second chunk

    logic [31:0] wt, wnew, tmp, wword;
    logic [7:0]  pbyte, f0, f1, f2, f3;
    logic [159:0] dig;
    logic [63:0]  bits;
    logic [3:0]   widx;

    // The schedule runs in place on a 16-word window.
    assign wnew = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 5'd1);
    assign wt   = (r_t < 7'd16) ? r_w[r_t[3:0]] : wnew;
    assign tmp  = rotl(r_v[0], 5'd5) + f_of(r_t, r_v[1], r_v[2], r_v[3])
                + r_v[4] + k_of(r_t) + wt;

    assign bits  = {49'd0, r_len, 3'b000};
    assign widx  = r_pos[5:2];
    // When the marker lands at offset 56 or later, the length goes into a second chunk.
    always_comb begin
        if (!r_wrap && r_pos == r_len[5:0])
            pbyte = 8'h80;
        else if (r_pos >= 6'd56 && (r_len[5:0] < 6'd56 || r_wrap))
            pbyte = bits[8*(7-(r_pos-6'd56)) +: 8];
        else
            pbyte = 8'h00;
    end
    always_comb begin
        logic [7:0] b;
        b = (r_state == S_PAD) ? pbyte : i_q_ent.hash_byte;
        case (r_pos[1:0])
            2'd0:    wword = {b, 24'd0};
            2'd1:    wword = r_w[widx] | {8'd0, b, 16'd0};
            2'd2:    wword = r_w[widx] | {16'd0, b, 8'd0};
            default: wword = r_w[widx] | {24'd0, b};
        endcase
    end

    assign dig = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
    assign f0 = dig[159:152] ^ dig[151:144] ^ dig[143:136] ^ dig[135:128] ^ dig[127:120];
    assign f1 = dig[119:112] ^ dig[111:104] ^ dig[103:96]  ^ dig[95:88]   ^ dig[87:80];
    assign f2 = dig[79:72]   ^ dig[71:64]   ^ dig[63:56]   ^ dig[55:48]   ^ dig[47:40];
    assign f3 = dig[39:32]   ^ dig[31:24]   ^ dig[23:16]   ^ dig[15:8]    ^ dig[7:0];

    assign o_q_ready      = r_state == S_IDLE;
    assign o_valid        = r_state == S_OUT;
    assign o_check_value  = r_chk;
    assign o_stored_check = r_stored;
    assign o_check_ok     = r_chk == r_stored;
    assign o_too_long     = r_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_len   <= '0;
            r_pos   <= '0;
            r_t     <= '0;
            r_wrap  <= 1'b0;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_stored <= i_q_ent.stored;
                        r_over   <= i_q_ent.over;
                        if (i_q_ent.keep) begin
                            r_w[widx] <= wword;
                            r_pos <= r_pos + 1'b1;
                            r_len <= r_len + 1'b1;
                        end
                        r_ret <= i_q_ent.last ? S_PAD : S_IDLE;
                        if (i_q_ent.keep && r_pos == 6'd63) begin
                            r_state <= S_ROUND;
                            r_t <= '0;
                            for (int i = 0; i < 5; i++) r_v[i] <= r_h[i];
                        end else if (i_q_ent.last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_ROUND: begin
                    r_v[4] <= r_v[3];
                    r_v[3] <= r_v[2];
                    r_v[2] <= rotl(r_v[1], 5'd30);
                    r_v[1] <= r_v[0];
                    r_v[0] <= tmp;
                    if (r_t >= 7'd16) begin
                        for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                        r_w[15] <= wnew;
                    end
                    if (r_t == 7'd79) begin
                        r_h[0] <= r_h[0] + tmp;
                        r_h[1] <= r_h[1] + r_v[0];
                        r_h[2] <= r_h[2] + rotl(r_v[1], 5'd30);
                        r_h[3] <= r_h[3] + r_v[2];
                        r_h[4] <= r_h[4] + r_v[3];
                        r_state <= (r_ret == S_PAD && r_pos == 6'd0 && r_len[5:0] != 6'd0
                                    && r_ret == S_PAD) ? S_PAD : r_ret;
                    end
                    r_t <= r_t + 1'b1;
                end
                S_PAD: begin
                    // One padding byte a cycle; the length ends the final chunk.
                    r_w[widx] <= wword;
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == 6'd63) begin
                        r_ret   <= (r_len[5:0] > 6'd55 && !r_wrap) ? S_PAD : S_FOLD;
                        r_wrap  <= r_len[5:0] > 6'd55 && !r_wrap;
                        r_state <= S_ROUND;
                        r_t <= '0;
                        for (int i = 0; i < 5; i++) r_v[i] <= r_h[i];
                    end
                end
                S_FOLD: begin
                    r_chk   <= {f0, f1, f2, f3};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                        r_len   <= '0;
                        r_pos   <= '0;
                        r_wrap  <= 1'b0;
                        r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2;
                        r_h[3] <= H3; r_h[4] <= H4;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/registry_block_check_unit.sv
// Registry block check unit: folded SHA-1 check over one block, one byte per beat.
// Each kept byte is packed into a 64-byte chunk, compressed each time the chunk fills.
// The final beat adds padding and one or two compressions, then the fold.
// The SHA-1 unit runs one round per cycle, and the engine takes no new byte while it
// compresses, pads or holds a result. Synchronous active-low reset returns the control
// state and the hash values to their initial values, with the queue empty.
module registry_block_check_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_check_value,
    output logic [31:0] o_stored_check,
    output logic        o_check_ok,
    output logic        o_too_long
);
    import rbc_pkg::*;

    t_qent f_ent, q_ent;
    logic  f_valid, f_ready, q_valid, q_ready;

    rbc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data_byte, .i_last_byte,
        .o_q_valid(f_valid), .i_q_ready(f_ready), .o_q_ent(f_ent)
    );

    rbc_queue u_queue (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_ent(f_ent),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_ent(q_ent)
    );

    rbc_engine u_engine (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_ent(q_ent),
        .o_valid, .i_ready, .o_check_value, .o_stored_check, .o_check_ok, .o_too_long
    );
endmodule

FILE: sim/registry_block_check_unit_checker.sv
// Checker for the registry block check unit: watches both channels, predicts each
// result with its own folded SHA-1 and compares it field by field. Uses rbc_pkg.
`timescale 1ns / 100ps

module registry_block_check_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_check_value,
    input  logic [31:0] o_stored_check,
    input  logic        o_check_ok,
    input  logic        o_too_long,
    output int          o_fail_count,
    output int          o_pending
);
    import rbc_pkg::*;

    typedef struct {
        logic [31:0] check;
        logic [31:0] stored;
        logic        ok;
        logic        over;
    } t_verdict;

    t_verdict    verdict_q[$];
    logic [7:0]  kept_bytes[$];
    logic [31:0] captured;
    logic        overflowed;

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // Standard SHA-1 over the kept bytes with the check bytes hashed as zero,
    // then the digest folded five bytes into each check byte.
    function automatic logic [31:0] fold_check(input logic [7:0] bytes [$]);
        logic [31:0] h[5];
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        logic [7:0]  m[$];
        logic [63:0] bit_len;
        logic [7:0]  x;
        logic [31:0] folded;
        int          n;
        m = bytes;
        for (int i = CheckOffset; i < CheckOffset + CheckLen; i++)
            if (i < m.size()) m[i] = 8'h00;
        bit_len = 64'(m.size()) * 8;
        m.push_back(8'h80);
        while (m.size() % 64 != 56) m.push_back(8'h00);
        for (int i = 0; i < 8; i++) m.push_back(bit_len[63 - 8 * i -: 8]);
        h[0] = H0; h[1] = H1; h[2] = H2; h[3] = H3; h[4] = H4;
        for (int base = 0; base < m.size(); base += 64) begin
            for (int t = 0; t < 16; t++)
                w[t] = {m[base + 4 * t], m[base + 4 * t + 1],
                        m[base + 4 * t + 2], m[base + 4 * t + 3]};
            for (int t = 16; t < 80; t++)
                w[t] = rot_left(w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 20) begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                tmp = rot_left(a, 5) + f + e + k + w[t];
                e = d; d = c; c = rot_left(b, 30); b = a; a = tmp;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
        end
        folded = '0;
        for (int q = 0; q < 4; q++) begin
            x = '0;
            for (int i = 0; i < 5; i++) begin
                n = 5 * q + i;
                x ^= h[n / 4][31 - 8 * (n % 4) -: 8];
            end
            folded[31 - 8 * q -: 8] = x;
        end
        return folded;
    endfunction

    assign o_pending = verdict_q.size();

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            kept_bytes.delete();
            verdict_q.delete();
            captured = '0;
            overflowed = 1'b0;
            o_fail_count = 0;
        end else begin
            if (i_valid && o_ready) begin
                if (kept_bytes.size() < MaxBytes) begin
                    if (kept_bytes.size() >= CheckOffset &&
                        kept_bytes.size() < CheckOffset + CheckLen)
                        captured[31 - 8 * (kept_bytes.size() - CheckOffset) -: 8] =
                            i_data_byte;
                    kept_bytes.push_back(i_data_byte);
                end else begin
                    overflowed = 1'b1;
                end
                if (i_last_byte) begin
                    want.check  = fold_check(kept_bytes);
                    want.stored = captured;
                    want.ok     = (want.check == captured);
                    want.over   = overflowed;
                    verdict_q.push_back(want);
                    kept_bytes.delete();
                    captured = '0;
                    overflowed = 1'b0;
                end
            end
            if (o_valid && i_ready) begin
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("ERROR: result beat with nothing expected: check %h",
                                 o_check_value);
                end else begin
                    want = verdict_q.pop_front();
                    if (o_check_value !== want.check || o_stored_check !== want.stored ||
                        o_check_ok !== want.ok || o_too_long !== want.over) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("ERROR: expected %h %h %b %b, got %h %h %b %b",
                                     want.check, want.stored, want.ok, want.over,
                                     o_check_value, o_stored_check, o_check_ok, o_too_long);
                    end
                end
            end
        end
    end

endmodule

FILE: sim/registry_block_check_unit_tb.sv
// Testbench top for the registry block check unit: clock, reset, block stimulus
// and verdict. Depends on rbc_pkg, the unit and registry_block_check_unit_checker.
`timescale 1ns / 100ps

module registry_block_check_unit_tb;
    import rbc_pkg::*;

    localparam int StallLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_check_value;
    logic [31:0] o_stored_check;
    logic        o_check_ok;
    logic        o_too_long;
    int          fail_count;
    int          pending;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_start = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   random_items = 0;

    always #4 i_clk = ~i_clk;

    registry_block_check_unit DUT (.*);

    registry_block_check_unit_checker u_chk (
        .o_fail_count(fail_count),
        .o_pending(pending),
        .*
    );

    // Receiver side, including one long hold-off that it times itself.
    always @(posedge i_clk) begin
        if (hold_start && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= 400;
            i_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_beat(input logic [7:0] value, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= value;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // mode: 0 random bytes, 1 all zero, 2 all ones; matched plants the right check.
    task automatic send_record(input int len, input int mode, input logic matched);
        logic [7:0]  bytes[$];
        logic [31:0] chk;
        for (int i = 0; i < len; i++)
            bytes.push_back(mode == 1 ? 8'h00 : mode == 2 ? 8'hFF : 8'($urandom));
        if (matched && len >= CheckOffset + CheckLen) begin
            chk = u_chk.fold_check(bytes);
            for (int i = 0; i < CheckLen; i++)
                bytes[CheckOffset + i] = chk[31 - 8 * i -: 8];
        end
        for (int i = 0; i < len; i++) send_beat(bytes[i], i == len - 1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tiny and short records, padding edges, solid values, matches.
        send_record(1, 0, 1'b0);
        send_record(1, 2, 1'b0);
        send_record(17, 2, 1'b0);
        send_record(18, 0, 1'b1);
        send_record(55, 1, 1'b0);
        send_record(56, 2, 1'b0);
        send_record(64, 0, 1'b1);
        send_record(65, 0, 1'b0);

        // Length limit: surplus bytes, the last one dropped too.
        send_record(MaxBytes + 2, 0, 1'b0);
        drain();

        // Back-pressure: results held off while short records keep coming.
        hold_start <= 1'b1;
        for (int i = 0; i < 6; i++) send_record(5, 0, 1'b0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 65; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 65; end
                default: begin send_idle_pct = 19; recv_idle_pct = 19; end
            endcase
            random_items = 0;
            while (random_items < 175) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 40);
                send_record(len, ($urandom_range(19) == 0) ? $urandom_range(1, 2) : 0,
                            $urandom_range(2) == 0);
                random_items += len;
            end
            if (phase == 1) drain();
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: registry_block_check_unit.f
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_front.sv
hw/rtl/rbc_queue.sv
hw/rtl/rbc_engine.sv
hw/rtl/registry_block_check_unit.sv
sim/registry_block_check_unit_checker.sv
sim/registry_block_check_unit_tb.sv
